// ===== rtl/core/shah_pkg.sv =====
// ----------------------------------------------------------------------------
// shah_pkg: shared types and constants for the SHA-256 message hasher
// Round constants, initial hash values and the round datapath control.
// ----------------------------------------------------------------------------
package shah_pkg;

  localparam int WordW  = 32;
  localparam int CountW = 61;

  typedef struct packed {
    logic       load;   // shift a hash word into the working variables
    logic       round;  // run one compression round
    logic       add;    // step the working variables out for the final add
    logic [5:0] t;      // round number
  } rnd_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/core/sha256_message_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_core: byte-serial SHA-256 hasher
// Packs message bytes into a block RAM, compresses into a hash RAM, pads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction per message byte
//   (in_byte_valid) and/or end-of-message flag. Items with neither flag
//   are consumed with no effect. A byte that fills the 64-byte block starts
//   a compression (hash RAM reads and block prefetch, 64 rounds at one per
//   cycle, hash add/write-back), its rate set by the single round unit and
//   the single read port of the hash RAM.
//   End of message: padding writes 1 to 16 block words, one per cycle, then
//   one or two compressions, then eight output transactions (digest words
//   H0..H7, out_last_word on the eighth), each read from the hash RAM
//   (S_OUT_RD) and then loaded into the output register (S_OUT_LD).
//   The result channel has an output register; the next message may start
//   while the last digest word waits. A stall on out_ready holds the
//   digest sequence. Reset (rst_n low, synchronous) clears the byte count,
//   marks the hash RAM as holding the initial hash values and idles the FSM.
//   in_ready is high only while the block is idle.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_OUT_RD, S_OUT_LD
  } state_t;

  typedef enum logic [1:0] { A_IDLE, A_PAD, A_PAD2, A_OUT } after_t;

  state_t      state_r;
  after_t      after_r;
  logic [5:0]  cnt_r;
  logic [3:0]  pad_idx_r;
  logic        pad_two_r;  // second padding block in progress
  logic [2:0]  o_idx_r;
  logic [60:0] count_r, count_nxt;
  logic [31:0] part_r, part_nxt;
  logic [7:0]  hvalid_r;
  logic        hv_q_r;
  logic [2:0]  haddr_q_r;
  logic        out_valid_r;

  logic        accept;
  logic        bwe, bre, hwe, hre;
  logic [3:0]  bwaddr, braddr;
  logic [31:0] bwdata, brdata;
  logic [2:0]  hwaddr, hraddr;
  logic [31:0] hwdata, hram_q, hd, v0;
  logic [31:0] pad_word, pad_data;
  logic [1:0]  lane;
  logic        two_blk;
  shah_pkg::rnd_ctl_t rctl;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // byte packing
  always_comb begin
    lane = count_r[1:0];
    if (lane == 2'd0) begin
      part_nxt = {in_data_byte, 24'h0};
    end else begin
      part_nxt = part_r | (32'(in_data_byte) << {~lane, 3'b000});
    end
    count_nxt = count_r + 61'd1;
    if (lane == 2'd0) begin
      pad_word = 32'h8000_0000;
    end else begin
      pad_word = part_r | (32'h80 << {~lane, 3'b000});
    end
    two_blk = (count_r[5:3] == 3'b111);
    pad_data = 32'h0;
    if (pad_two_r) begin
      if (pad_idx_r == 4'd14) pad_data = count_r[60:29];
      else if (pad_idx_r == 4'd15) pad_data = {count_r[28:0], 3'b000};
    end else if (pad_idx_r == count_r[5:2]) begin
      pad_data = pad_word;
    end else if (!two_blk && pad_idx_r == 4'd14) begin
      pad_data = count_r[60:29];
    end else if (!two_blk && pad_idx_r == 4'd15) begin
      pad_data = {count_r[28:0], 3'b000};
    end
  end

  // memory port control
  always_comb begin
    bwe    = 1'b0;
    bwaddr = count_r[5:2];
    bwdata = part_nxt;
    bre    = 1'b0;
    braddr = 4'd0;
    hwe    = 1'b0;
    hwaddr = 3'(cnt_r - 6'd1);
    hwdata = hd + v0;
    hre    = 1'b0;
    hraddr = cnt_r[2:0];
    rctl   = '{load: 1'b0, round: 1'b0, add: 1'b0, t: cnt_r};
    case (state_r)
      S_IDLE: begin
        bwe = accept && in_byte_valid && (lane == 2'd3);
      end
      S_LOAD: begin
        hre       = (cnt_r < 6'd8);
        rctl.load = (cnt_r != 6'd0);
        bre       = (cnt_r == 6'd8);
      end
      S_ROUND: begin
        rctl.round = 1'b1;
        bre        = (cnt_r < 6'd15);
        braddr     = 4'(cnt_r + 6'd1);
      end
      S_ADD: begin
        hre      = (cnt_r < 6'd8);
        hwe      = (cnt_r != 6'd0);
        rctl.add = (cnt_r != 6'd0);
      end
      S_PAD: begin
        bwe    = 1'b1;
        bwaddr = pad_idx_r;
        bwdata = pad_data;
      end
      S_OUT_RD: begin
        hre    = !out_valid_r || out_ready;
        hraddr = o_idx_r;
      end
      default: ;
    endcase
  end

  shah_ram #(.W(32), .DEPTH(16)) u_blk_ram (
    .clk(clk), .we(bwe), .waddr(bwaddr), .wdata(bwdata),
    .re(bre), .raddr(braddr), .rdata(brdata)
  );

  shah_ram #(.W(32), .DEPTH(8)) u_hash_ram (
    .clk(clk), .we(hwe), .waddr(hwaddr), .wdata(hwdata),
    .re(hre), .raddr(hraddr), .rdata(hram_q)
  );

  // entries not yet written since reset or the last digest read as the IV
  assign hd = hv_q_r ? hram_q : shah_pkg::init_hash(haddr_q_r);

  shah_round u_round (
    .clk(clk), .ctl(rctl), .hash_in(hd), .w_blk(brdata), .v0(v0)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= A_IDLE;
      cnt_r       <= '0;
      pad_idx_r   <= '0;
      pad_two_r   <= 1'b0;
      o_idx_r     <= '0;
      count_r     <= '0;
      hvalid_r    <= '0;
      hv_q_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (hre) begin
        hv_q_r    <= hvalid_r[hraddr];
        haddr_q_r <= hraddr;
      end
      if (hwe) begin
        hvalid_r[hwaddr] <= 1'b1;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_byte_valid) begin
              part_r  <= part_nxt;
              count_r <= count_nxt;
            end
            if (in_byte_valid && count_r[5:0] == 6'd63) begin
              state_r <= S_LOAD;
              cnt_r   <= '0;
              after_r <= in_end_of_message ? A_PAD : A_IDLE;
            end else if (in_end_of_message) begin
              state_r   <= S_PAD;
              pad_two_r <= 1'b0;
              pad_idx_r <= in_byte_valid ? count_nxt[5:2] : count_r[5:2];
            end
          end
        end
        S_LOAD: begin
          if (cnt_r == 6'd8) begin
            cnt_r   <= '0;
            state_r <= S_ROUND;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_ROUND: begin
          if (cnt_r == 6'd63) begin
            cnt_r   <= '0;
            state_r <= S_ADD;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_ADD: begin
          if (cnt_r == 6'd8) begin
            cnt_r <= '0;
            case (after_r)
              A_IDLE: state_r <= S_IDLE;
              A_PAD: begin
                state_r   <= S_PAD;
                pad_two_r <= 1'b0;
                pad_idx_r <= count_r[5:2];
              end
              A_PAD2: begin
                state_r   <= S_PAD;
                pad_two_r <= 1'b1;
                pad_idx_r <= '0;
              end
              A_OUT: begin
                state_r <= S_OUT_RD;
                o_idx_r <= '0;
              end
              default: state_r <= S_IDLE;
            endcase
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_PAD: begin
          pad_idx_r <= pad_idx_r + 4'd1;
          if (pad_idx_r == 4'd15) begin
            state_r <= S_LOAD;
            cnt_r   <= '0;
            after_r <= (!pad_two_r && two_blk) ? A_PAD2 : A_OUT;
          end
        end
        S_OUT_RD: begin
          if (hre) begin
            state_r <= S_OUT_LD;
          end
        end
        S_OUT_LD: begin
          out_valid_r     <= 1'b1;
          out_digest_word <= hd;
          out_word_index  <= o_idx_r;
          out_last_word   <= (o_idx_r == 3'd7);
          o_idx_r         <= o_idx_r + 3'd1;
          if (o_idx_r == 3'd7) begin
            // next message starts from the initial hash
            hvalid_r <= '0;
            count_r  <= '0;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_OUT_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_blk_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(bwe && bre))
    else $error("block RAM written and read in the same cycle");

  a_add_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && cnt_r != 6'd0) |-> hwe && !bwe)
    else $error("hash write-back missing");

  a_iv_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_LD && o_idx_r == 3'd7) |=> (hvalid_r == 8'h00 && count_r == '0))
    else $error("hash not reloaded after digest");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_LD) |-> !out_valid_r)
    else $error("output register overwritten");
`endif

endmodule

// ===== rtl/core/shah_ram.sv =====
// ----------------------------------------------------------------------------
// shah_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module shah_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/shah_round.sv =====
// ----------------------------------------------------------------------------
// shah_round: SHA-256 round datapath
// Working variables, 16-word schedule window and one round per cycle.
// ----------------------------------------------------------------------------
module shah_round (
  input  logic               clk,
  input  shah_pkg::rnd_ctl_t ctl,
  input  logic [31:0]        hash_in,
  input  logic [31:0]        w_blk,
  output logic [31:0]        v0
);

  logic [31:0] v_r [8];
  logic [31:0] sr_r [16];   // sr_r[15] = W[t-1], sr_r[0] = W[t-16]
  logic [31:0] wt, s0, s1, big0, big1, ch, maj, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    s1   = rotr(sr_r[14], 17) ^ rotr(sr_r[14], 19) ^ (sr_r[14] >> 10);
    s0   = rotr(sr_r[1], 7) ^ rotr(sr_r[1], 18) ^ (sr_r[1] >> 3);
    wt   = (ctl.t < 6'd16) ? w_blk : s1 + sr_r[9] + s0 + sr_r[0];
    big1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + shah_pkg::round_k(ctl.t) + wt;
    big0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.add) begin
      for (int k = 0; k < 7; k++) begin
        v_r[k] <= v_r[k+1];
      end
      v_r[7] <= hash_in;
    end else if (ctl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int k = 0; k < 15; k++) begin
        sr_r[k] <= sr_r[k+1];
      end
      sr_r[15] <= wt;
    end
  end

  assign v0 = v_r[0];

endmodule

// ===== bench/sha256_digest_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_digest_checker: digest predictor and scoreboard
// Watches both channels, hashes accepted bytes with its own SHA-256 model and
// compares each digest word against the oldest predicted one.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          err_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0] blk [16];
  logic [31:0] hash [8];
  logic [60:0] byte_cnt;
  digest_word_t digest_q [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = blk[t];
      end else begin
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
    end
    for (int i = 0; i < 8; i++) v[i] = hash[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shah_pkg::round_k(t[5:0]) + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash[i] = hash[i] + v[i];
  endtask

  task automatic place_byte(input logic [5:0] pos, input logic [7:0] b);
    if (pos[1:0] == 2'd0) blk[pos[5:2]] = {b, 24'h0};
    else blk[pos[5:2]] |= 32'(b) << ((3 - pos[1:0]) * 8);
  endtask

  task automatic init_state();
    for (int i = 0; i < 8; i++) hash[i] = shah_pkg::init_hash(i[2:0]);
    byte_cnt = '0;
  endtask

  task automatic hash_item(input logic [7:0] b, input logic bv, input logic eom);
    logic [5:0] pos;
    logic [63:0] bits;
    digest_word_t d;
    if (bv) begin
      pos = byte_cnt[5:0];
      place_byte(pos, b);
      byte_cnt = byte_cnt + 1'b1;
      if (pos == 6'd63) compress();
    end
    if (!eom) return;
    pos = byte_cnt[5:0];
    place_byte(pos, 8'h80);
    for (int i = pos[5:2] + 1; i < 16; i++) blk[i] = '0;
    if (pos >= 6'd56) begin
      compress();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    bits = {byte_cnt, 3'b000};
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.word = hash[i];
      d.idx = i[2:0];
      d.last = (i == 7);
      digest_q.push_back(d);
    end
    init_state();
  endtask

  initial begin
    err_count = 0;
    pending_words = 0;
    init_state();
  end

  always @(posedge clk) begin
    digest_word_t e;
    if (!rst_n) begin
      init_state();
    end else begin
      if (in_valid && in_ready) hash_item(in_data_byte, in_byte_valid, in_end_of_message);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word exp=none act=%h idx=%0d last=%0b",
                   $time, out_digest_word, out_word_index, out_last_word);
          err_count++;
        end else begin
          e = digest_q.pop_front();
          if (e.word !== out_digest_word) begin
            $display("%0t: digest_word exp=%h act=%h", $time, e.word, out_digest_word);
            err_count++;
          end
          if (e.idx !== out_word_index) begin
            $display("%0t: word_index exp=%0d act=%0d", $time, e.idx, out_word_index);
            err_count++;
          end
          if (e.last !== out_last_word) begin
            $display("%0t: last_word exp=%0b act=%0b", $time, e.last, out_last_word);
            err_count++;
          end
        end
      end
    end
    pending_words = digest_q.size();
  end
endmodule

// ===== bench/tb_sha256_message_hasher_core.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_message_hasher_core: testbench for the byte-serial SHA-256 hasher
// Directed messages (empty, padding boundaries, block fills, idle items) and
// then random messages with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sha256_message_hasher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          err_count;
  int          pending_words;
  int          idle_cycles = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          n_items = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sha256_message_hasher_core u_top (.*);

  sha256_digest_checker u_chk (.*);

  // receiver: phases of free flow, random stalls and long holds
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one transaction, with burst/gap pacing between items
  task automatic send(input logic [7:0] b, input logic bv, input logic eom);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        repeat (gap_left) @(negedge clk);
      end
    end
    burst_left--;
    n_items++;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_byte_valid <= bv;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_msg(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(0, 1)) begin
        send(8'($urandom), 1'b1, 1'b1);
        return;
      end
      send(8'($urandom), 1'b1, 1'b0);
    end
    send(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    // directed: empty, idle item, field extremes, padding edges
    send(8'h00, 1'b0, 1'b1);
    send(8'hff, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b1);
    send(8'h61, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b0);
    send(8'h63, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);
    send_msg(55);
    send_msg(56);
    send_msg(63);
    send_msg(64);
    while (n_items < 350) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 130)
                                        : $urandom_range(0, 12);
      if (len > 355 - n_items) len = 355 - n_items;
      send_msg(len);
    end
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
